>>> rtl/core/pls_pkg.sv
// Shared types and codes for the piecewise-linear table sampler.
// Used by the top level and by the serial divider; depends on nothing.
`default_nettype none

package pls_pkg;

   localparam int WL_W     = 16;   // Unsigned Q12.4 wavelength.
   localparam int VALUE_W  = 16;   // Signed Q8.8 value.
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;    // Width of the reported point count.
   localparam int PROD_W   = 2 * VALUE_W;

   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_APPEND   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd2;
   // The remaining code leaves the table alone and answers with status ok.
   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STS_ORDER = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [WL_W-1:0]           wavelength;
      logic signed [VALUE_W-1:0] point_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sampled_value;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        point_count;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/pls_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pls_pkg for operand widths.
`default_nettype none

module pls_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [pls_pkg::PROD_W-1:0]       dividend,
   input  wire logic [pls_pkg::WL_W-1:0]         divisor,
   output logic                                  done,
   output logic [pls_pkg::VALUE_W-1:0]           quotient
);

   localparam int HALF_W = pls_pkg::PROD_W - pls_pkg::VALUE_W;
   localparam int STEP_W = $clog2(pls_pkg::VALUE_W);

   logic [pls_pkg::WL_W-1:0]    rem_ff;
   logic [HALF_W-1:0]           num_ff;
   logic [pls_pkg::VALUE_W-1:0] quo_ff;
   logic [STEP_W-1:0]           step_ff;
   logic                        run_ff;
   logic                        done_ff;

   logic [pls_pkg::WL_W:0]      trial;
   logic                        fits;

   // The caller guarantees the quotient fits in VALUE_W bits, so the upper half
   // of the dividend is already below the divisor and only the low bits iterate.
   assign trial = {rem_ff, num_ff[HALF_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend[pls_pkg::PROD_W-1:HALF_W];
            num_ff  <= dividend[HALF_W-1:0];
            step_ff <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            if (fits) begin
               rem_ff <= pls_pkg::WL_W'(trial - {1'b0, divisor});
            end else begin
               rem_ff <= trial[pls_pkg::WL_W-1:0];
            end
            num_ff  <= {num_ff[HALF_W-2:0], 1'b0};
            quo_ff  <= {quo_ff[pls_pkg::VALUE_W-2:0], fits};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(pls_pkg::VALUE_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/piecewise_linear_table_sampler.sv
// Top level of the piecewise-linear table sampler: point table, scan sequencer,
// multiplier stage and response register. Depends on pls_pkg and pls_divider.
`default_nettype none

// The block holds up to TABLE_DEPTH ascending (wavelength, value) points and
// handles one request at a time. Clear and append requests finish in the
// cycle they are accepted and their response is registered for the next
// cycle. A sample request walks the table through its single read port, one
// entry per cycle, until it reaches the first point above the query; it then
// registers the product in the multiply state, starts the divider and waits
// for the bit-serial divider to finish. A sample that falls outside the table
// ends as soon as that is known. A new request is taken when the sequencer is
// idle and the response register is free or being emptied in the same cycle.
module piecewise_linear_table_sampler #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire pls_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output pls_pkg::rsp_type      rsp_payload
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WL_W   = pls_pkg::WL_W;
   localparam int VAL_W  = pls_pkg::VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [WL_W-1:0]          last_wl_ff;
   logic [WL_W-1:0]          query_ff;
   logic [CNT_W-1:0]         fetch_ff;
   logic [CNT_W-1:0]         chk_idx_ff;
   logic                     chk_vld_ff;
   logic [WL_W-1:0]          prev_wl_ff;
   logic signed [VAL_W-1:0]  prev_val_ff;
   logic signed [VAL_W-1:0]  y0_ff;
   logic [VAL_W-1:0]         dy_mag_ff;
   logic                     neg_ff;
   logic [WL_W-1:0]          dx_ff;
   logic [WL_W-1:0]          den_ff;
   logic [pls_pkg::PROD_W-1:0] prod_ff;
   logic                     div_start_ff;
   logic                     rsp_valid_ff;
   pls_pkg::rsp_type         rsp_ff;

   logic [WL_W-1:0]          wl_mem [TABLE_DEPTH];
   logic [VAL_W-1:0]         val_mem [TABLE_DEPTH];
   logic [WL_W-1:0]          rd_wl_ff;
   logic signed [VAL_W-1:0]  rd_val_ff;

   logic                     accept;
   logic                     table_full;
   logic                     append_order_bad;
   logic                     append_ok;
   logic [CNT_W-1:0]         count_inc;
   logic [CNT_W-1:0]         last_idx;
   logic [CNT_W+pls_pkg::COUNT_W-1:0] count_ext;
   logic [CNT_W+pls_pkg::COUNT_W-1:0] count_inc_ext;
   logic                     below_first;
   logic                     hit;
   logic signed [VAL_W:0]    dy;
   logic [VAL_W:0]           dy_abs;
   logic                     div_done;
   logic [VAL_W-1:0]         div_quo;
   logic signed [VAL_W:0]    q_signed;
   logic signed [VAL_W:0]    y_sum;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign table_full       = count_ff >= CNT_W'(TABLE_DEPTH);
   assign append_order_bad = (count_ff != '0) && (req_payload.wavelength <= last_wl_ff);
   assign append_ok        = accept && (req_payload.action == pls_pkg::ACT_APPEND)
                             && !table_full && !append_order_bad;
   assign count_inc        = count_ff + 1'b1;
   assign last_idx         = count_ff - 1'b1;

   // The reported count is the low bits of the count, whatever the depth.
   assign count_ext     = {{pls_pkg::COUNT_W{1'b0}}, count_ff};
   assign count_inc_ext = {{pls_pkg::COUNT_W{1'b0}}, count_inc};

   assign below_first = (chk_idx_ff == '0) && (query_ff < rd_wl_ff);
   assign hit         = (chk_idx_ff != '0) && (rd_wl_ff > query_ff);

   assign dy     = {rd_val_ff[VAL_W-1], rd_val_ff} - {prev_val_ff[VAL_W-1], prev_val_ff};
   assign dy_abs = dy[VAL_W] ? (VAL_W+1)'(-dy) : dy;

   assign q_signed = neg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
   assign y_sum    = {y0_ff[VAL_W-1], y0_ff} + q_signed;

   // Table storage: one write port for appends, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (append_ok) begin
         wl_mem[count_ff[ADDR_W-1:0]]  <= req_payload.wavelength;
         val_mem[count_ff[ADDR_W-1:0]] <= req_payload.point_value;
      end
      rd_wl_ff  <= wl_mem[fetch_ff[ADDR_W-1:0]];
      rd_val_ff <= val_mem[fetch_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_ff.sampled_value <= '0;
                  rsp_ff.status        <= pls_pkg::STS_OK;
                  rsp_ff.point_count   <= count_ext[pls_pkg::COUNT_W-1:0];
                  rsp_valid_ff         <= 1'b1;
                  unique case (req_payload.action)
                     pls_pkg::ACT_CLEAR: begin
                        count_ff           <= '0;
                        rsp_ff.point_count <= '0;
                     end
                     pls_pkg::ACT_APPEND: begin
                        if (table_full) begin
                           rsp_ff.status <= pls_pkg::STS_FULL;
                        end else if (append_order_bad) begin
                           rsp_ff.status <= pls_pkg::STS_ORDER;
                        end else begin
                           count_ff           <= count_inc;
                           last_wl_ff         <= req_payload.wavelength;
                           rsp_ff.point_count <= count_inc_ext[pls_pkg::COUNT_W-1:0];
                        end
                     end
                     pls_pkg::ACT_SAMPLE: begin
                        if (count_ff == '0) begin
                           rsp_ff.status <= pls_pkg::STS_RANGE;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           query_ff     <= req_payload.wavelength;
                           fetch_ff     <= '0;
                           chk_vld_ff   <= 1'b0;
                           state_ff     <= ST_SCAN;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end

            ST_SCAN: begin
               // Reads are issued in the cycle before the compare.
               chk_idx_ff <= fetch_ff;
               chk_vld_ff <= fetch_ff < count_ff;
               if (fetch_ff < count_ff) begin
                  fetch_ff <= fetch_ff + 1'b1;
               end
               if (chk_vld_ff) begin
                  if (hit) begin
                     y0_ff     <= prev_val_ff;
                     dy_mag_ff <= dy_abs[VAL_W-1:0];
                     neg_ff    <= dy[VAL_W];
                     dx_ff     <= query_ff - prev_wl_ff;
                     den_ff    <= rd_wl_ff - prev_wl_ff;
                     state_ff  <= ST_MUL;
                  end else if (below_first || (chk_idx_ff == last_idx)) begin
                     rsp_ff.sampled_value <= '0;
                     rsp_ff.status        <= pls_pkg::STS_RANGE;
                     rsp_ff.point_count   <= count_ext[pls_pkg::COUNT_W-1:0];
                     rsp_valid_ff         <= 1'b1;
                     state_ff             <= ST_IDLE;
                  end else begin
                     prev_wl_ff  <= rd_wl_ff;
                     prev_val_ff <= rd_val_ff;
                  end
               end
            end

            ST_MUL: begin
               prod_ff      <= dy_mag_ff * dx_ff;
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end

            ST_DIV: begin
               if (div_done) begin
                  rsp_ff.sampled_value <= y_sum[VAL_W-1:0];
                  rsp_ff.status        <= pls_pkg::STS_OK;
                  rsp_ff.point_count   <= count_ext[pls_pkg::COUNT_W-1:0];
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   pls_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
